[rtl/core/ddd_pkg.sv]
// Shared types, constants and calendar tables for the day-difference unit.
// No dependencies; imported by ddd_day_num and date_difference_in_days_unit.
package ddd_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned DAYNUM_W  = 22;
  localparam int unsigned DIFF_W    = 23;
  localparam int unsigned QUOT_W    = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTHS       = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
  localparam int unsigned        DIV100_SHIFT = 19;
  localparam logic [12:0]        DIV100_MUL   = 13'd5243;
  localparam int unsigned        PROD_W       = YEAR_W + 13;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
  } in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] days_between;
    logic                     dates_valid;
  } out_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ddd_day_num.sv]
// Three-stage pipeline turning one date into a day number from 1/1/1, plus a
// validity flag. Depends on ddd_pkg; stage enables come from the top level.
module ddd_day_num (
  input  logic                           clk_i,
  input  ddd_pkg::stage_en_t             en_i,
  input  logic [ddd_pkg::DAY_W-1:0]      day_i,
  input  logic [ddd_pkg::MONTH_W-1:0]    month_i,
  input  logic [ddd_pkg::YEAR_W-1:0]     year_i,
  output logic [ddd_pkg::DAYNUM_W-1:0]   day_num_o,
  output logic                           ok_o
);
  import ddd_pkg::*;

  // stage 1: divide year by 100, range checks
  logic [PROD_W-1:0]  prod;
  logic [DAY_W-1:0]   d1_q, d2_q;
  logic [MONTH_W-1:0] m1_q, m2_q;
  logic [YEAR_W-1:0]  y1_q, p2_q;
  logic [QUOT_W-1:0]  q1_q, pd2_q;
  logic               rok1_q, leap2_q, ok2_q;

  assign prod = PROD_W'(year_i) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      d1_q   <= day_i;
      m1_q   <= month_i;
      y1_q   <= year_i;
      q1_q   <= prod[DIV100_SHIFT +: QUOT_W];
      rok1_q <= (month_i >= MONTH_W'(1)) && (month_i <= MONTHS) &&
                (year_i >= YEAR_W'(1)) && (year_i <= YEAR_MAX);
    end
  end

  // stage 2: remainder, leap rule, day check, (y-1)/100
  logic [YEAR_W-1:0] rem;
  logic              rem_zero, leap;

  assign rem      = y1_q - YEAR_W'(q1_q) * YEAR_W'(100);
  assign rem_zero = (rem == '0);
  assign leap     = rem_zero ? (q1_q[1:0] == 2'b00) : (y1_q[1:0] == 2'b00);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      d2_q    <= d1_q;
      m2_q    <= m1_q;
      p2_q    <= y1_q - YEAR_W'(1);
      pd2_q   <= rem_zero ? q1_q - QUOT_W'(1) : q1_q;
      leap2_q <= leap;
      ok2_q   <= rok1_q && (d1_q != '0) && (d1_q <= month_len(m1_q, leap));
    end
  end

  // stage 3: sum up the day number
  logic [DAYNUM_W-1:0] n;
  logic [DAYNUM_W-1:0] num3_q;
  logic                ok3_q;

  assign n = DAYNUM_W'(p2_q) * DAYNUM_W'(365) + DAYNUM_W'(p2_q[YEAR_W-1:2])
           - DAYNUM_W'(pd2_q) + DAYNUM_W'(pd2_q[QUOT_W-1:2])
           + DAYNUM_W'(days_before(m2_q))
           + DAYNUM_W'(leap2_q && (m2_q > MONTH_FEB))
           + DAYNUM_W'(d2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      num3_q <= n;
      ok3_q  <= ok2_q;
    end
  end

  assign day_num_o = num3_q;
  assign ok_o      = ok3_q;

endmodule

[rtl/core/date_difference_in_days_unit.sv]
// Days between two proleptic Gregorian dates: a new pair of dates can be
// taken every cycle unless the input is stalled, and passes through the
// pipeline (divide year by 100, leap rule and day check, day number sum,
// subtract). A stalled output lets the stages behind it fill any empty
// slots before the input is stalled. Depends on ddd_pkg and ddd_day_num.
module date_difference_in_days_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ddd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ddd_pkg::out_t out_data_o
);
  import ddd_pkg::*;

  logic      v1_q, v2_q, v3_q, v4_q;
  logic      en1, en2, en3, en4;
  stage_en_t sen;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign sen = '{s1: en1, s2: en2, s3: en3};
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  logic [DAYNUM_W-1:0] num_a, num_b;
  logic                ok_a, ok_b;

  ddd_day_num u_first (
    .clk_i     (clk_i),
    .en_i      (sen),
    .day_i     (in_data_i.first_day),
    .month_i   (in_data_i.first_month),
    .year_i    (in_data_i.first_year),
    .day_num_o (num_a),
    .ok_o      (ok_a)
  );

  ddd_day_num u_second (
    .clk_i     (clk_i),
    .en_i      (sen),
    .day_i     (in_data_i.second_day),
    .month_i   (in_data_i.second_month),
    .year_i    (in_data_i.second_year),
    .day_num_o (num_b),
    .ok_o      (ok_b)
  );

  out_t out_d, out_q;

  always_comb begin
    out_d.dates_valid  = ok_a && ok_b;
    out_d.days_between = out_d.dates_valid ?
                         signed'(DIFF_W'(num_b) - DIFF_W'(num_a)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en4) out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted beat missing from first stage");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.dates_valid) |-> (out_data_o.days_between == '0))
    else $error("invalid dates with nonzero day count");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.dates_valid) |->
      (out_data_o.days_between <= 23'sd3652058 &&
       out_data_o.days_between >= -23'sd3652058))
    else $error("day count out of range");

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

[tb/tb_date_difference_in_days_unit.sv]
// Testbench for date_difference_in_days_unit: sends pairs of dates, predicts the signed
// day count and the validity flag, and checks every result beat in order.
// Depends on ddd_pkg and the unit's RTL.
module tb_date_difference_in_days_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ddd_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  date_difference_in_days_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  out_t        expected_diffs[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned legal_pairs;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL date_difference_in_days_unit");
    $finish;
  end

  // ---------------- calendar predictor ----------------
  function automatic bit is_leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(int unsigned m, bit leap);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_is_legal(int unsigned d, int unsigned m, int unsigned y);
    if (m < 1 || m > 12 || y < 1 || y > 9999) return 1'b0;
    return d >= 1 && d <= month_length(m, is_leap_year(y));
  endfunction

  // day 1 is 1 January of year 1
  function automatic int day_ordinal(int unsigned d, int unsigned m, int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_length(k, is_leap_year(y));
    return n + d;
  endfunction

  function automatic out_t predict_days_between(in_t x);
    out_t        r;
    int          diff;
    int unsigned d1, m1, y1, d2, m2, y2;
    r  = '0;
    d1 = 32'(x.first_day);
    m1 = 32'(x.first_month);
    y1 = 32'(x.first_year);
    d2 = 32'(x.second_day);
    m2 = 32'(x.second_month);
    y2 = 32'(x.second_year);
    if (date_is_legal(d1, m1, y1) && date_is_legal(d2, m2, y2)) begin
      diff = day_ordinal(d2, m2, y2) - day_ordinal(d1, m1, y1);
      r.days_between = diff[DIFF_W-1:0];
      r.dates_valid  = 1'b1;
    end
    return r;
  endfunction

  // ---------------- monitor and checker ----------------
  always @(posedge clk_i) begin
    out_t got;
    out_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_diffs.push_back(predict_days_between(in_data_i));
        beats_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        beats_out++;
        if (expected_diffs.size() == 0) begin
          $display("%0t: result beat with nothing expected: days %0d valid %0b",
                   $time, got.days_between, got.dates_valid);
          mismatches++;
        end else begin
          exp_r = expected_diffs.pop_front();
          if (exp_r.dates_valid) legal_pairs++;
          if (got.days_between !== exp_r.days_between) begin
            $display("%0t: days_between expected %0d got %0d",
                     $time, exp_r.days_between, got.days_between);
            mismatches++;
          end
          if (got.dates_valid !== exp_r.dates_valid) begin
            $display("%0t: dates_valid expected %0b got %0b",
                     $time, exp_r.dates_valid, got.dates_valid);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic in_t pack_dates(int unsigned d1, int unsigned m1, int unsigned y1,
                                     int unsigned d2, int unsigned m2, int unsigned y2);
    in_t x;
    x.first_day    = d1[DAY_W-1:0];
    x.first_month  = m1[MONTH_W-1:0];
    x.first_year   = y1[YEAR_W-1:0];
    x.second_day   = d2[DAY_W-1:0];
    x.second_month = m2[MONTH_W-1:0];
    x.second_year  = y2[YEAR_W-1:0];
    return x;
  endfunction

  // mostly legal dates with stress on leap years and month ends, some noise
  function automatic void pick_date(output logic [DAY_W-1:0] d,
                                    output logic [MONTH_W-1:0] m,
                                    output logic [YEAR_W-1:0] y);
    int unsigned r;
    int unsigned yy;
    int unsigned mm;
    int unsigned last;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0:       yy = 100 * $urandom_range(1, 99);
      1:       yy = 4 * $urandom_range(1, 2499);
      2:       yy = $urandom_range(1, 30);
      3:       yy = $urandom_range(9970, 9999);
      default: yy = $urandom_range(1, 9999);
    endcase
    mm   = $urandom_range(1, 12);
    if (r >= 12 && r < 18) mm = 2;
    last = month_length(mm, is_leap_year(yy));
    y = yy[YEAR_W-1:0];
    m = mm[MONTH_W-1:0];
    d = DAY_W'($urandom_range(1, last));
    if (r >= 12 && r < 18) d = 5'd29;
    else if (r >= 18 && r < 24) d = last[DAY_W-1:0];
    else if (r >= 24 && r < 28) d = last[DAY_W-1:0] + 5'd1;
    if (r < 12) begin
      d = DAY_W'($urandom);
      m = MONTH_W'($urandom);
      y = YEAR_W'($urandom);
    end
  endfunction

  function automatic in_t random_dates();
    in_t x;
    pick_date(x.first_day, x.first_month, x.first_year);
    pick_date(x.second_day, x.second_month, x.second_year);
    if ($urandom_range(19) == 0) begin
      x.second_day   = x.first_day;
      x.second_month = x.first_month;
      x.second_year  = x.first_year;
    end
    return x;
  endfunction

  task automatic send_dates(input in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_diffs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------- tests ----------------
  task automatic test_calendar_edges();
    send_idle_pct = 27;
    recv_idle_pct = 72;
    send_dates(pack_dates(1, 1, 1, 31, 12, 9999));
    send_dates(pack_dates(31, 12, 9999, 1, 1, 1));
    send_dates(pack_dates(15, 6, 2024, 15, 6, 2024));
    send_dates(pack_dates(28, 2, 2000, 29, 2, 2000));
    send_dates(pack_dates(29, 2, 1900, 1, 3, 1900));
    send_dates(pack_dates(29, 2, 2024, 1, 3, 2023));
    send_dates(pack_dates(1, 1, 2023, 29, 2, 2023));
    send_dates(pack_dates(29, 2, 400, 29, 2, 9996));
    send_dates(pack_dates(30, 2, 2000, 1, 1, 2000));
    send_dates(pack_dates(0, 5, 1999, 1, 5, 1999));
    send_dates(pack_dates(31, 4, 2010, 1, 1, 2010));
    send_dates(pack_dates(31, 12, 1999, 1, 1, 2000));
    send_dates(pack_dates(1, 0, 1000, 1, 1, 1000));
    send_dates(pack_dates(1, 1, 1000, 1, 13, 1000));
    send_dates(pack_dates(1, 15, 1000, 1, 1, 1000));
    send_dates(pack_dates(1, 1, 0, 1, 1, 1));
    send_dates(pack_dates(1, 1, 1, 1, 1, 10000));
    send_dates(pack_dates(31, 15, 16383, 31, 15, 16383));
    send_dates(pack_dates(0, 0, 0, 0, 0, 0));
    send_dates(pack_dates(31, 12, 9999, 31, 12, 9999));
    send_dates(pack_dates(1, 3, 4, 28, 2, 4));
    send_dates(pack_dates(31, 1, 8191, 30, 11, 5461));
    wait_drained();
  endtask

  task automatic test_random_dates(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_dates(random_dates());
    wait_drained();
  endtask

  // receiver holds off long enough for the pipeline to back up into the input
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    hold_request  = 80;
    repeat (40) send_dates(random_dates());
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 40;
    repeat (20) send_dates(random_dates());
    wait_drained();
    repeat (20) send_dates(random_dates());
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;
    beats_in      = 0;
    beats_out     = 0;
    legal_pairs   = 0;
    mismatches    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calendar_edges();
    test_random_dates(27, 72, 450);
    test_random_dates(72, 27, 450);
    test_output_holdoff();
    test_drain_pause();
    test_random_dates(0, 0, 450);

    $display("Sent %0d date pairs, checked %0d results (%0d with both dates legal),",
             beats_in, beats_out, legal_pairs);
    $display("under both idle mixes, back to back, a long output hold-off and a drain pause");
    if (mismatches == 0) begin
      $display("PASS date_difference_in_days_unit");
    end else begin
      $display("FAIL date_difference_in_days_unit");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ddd_pkg.sv
rtl/core/ddd_day_num.sv
rtl/core/date_difference_in_days_unit.sv
tb/tb_date_difference_in_days_unit.sv
